>>> rtl/vnos_pkg.sv
// Package: constants, types and helper functions of the value noise octave sampler.
`timescale 1ns / 1ps
package vnos_pkg;

  localparam int LatticeSide = 32;
  localparam int FieldSide   = 4096;
  localparam int CosEntries  = 256;

  localparam int StoreDepth = LatticeSide * LatticeSide;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int ValW       = 31;
  localparam int StepW      = 24;
  localparam int SideW      = 6;
  localparam int ShiftW     = 5;
  localparam int CoordW     = $clog2(FieldSide);
  localparam int FracW      = 16;
  localparam int PosW       = CoordW + StepW;
  localparam int WrapW      = PosW - FracW + 1;
  localparam int RemW       = $clog2(LatticeSide);
  localparam int WeightW    = FracW + 1;
  localparam int RomIdxW    = $clog2(CosEntries);
  localparam int FieldW     = 32;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 24;

  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint unsigned OneQ30 = 64'd1073741824;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } vnos_op_e;

  localparam logic [CfgIdxW-1:0] CFG_STEP_X  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_Y  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_X = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT_Y = 3'd5;

  // item payload carried along the address pipeline
  typedef struct packed {
    vnos_op_e               op;
    logic [AddrW-1:0]       index;
    logic [ValW-1:0]        value;
    logic [FracW-1:0]       fx;
    logic [FracW-1:0]       fy;
    logic signed [FieldW-1:0] prior;
  } vnos_item_t;

  typedef logic [WeightW-1:0] weight_rom_t [CosEntries];

  // raised-cosine weight table, Q16, built at elaboration
  function automatic weight_rom_t build_weight_rom();
    weight_rom_t rom;
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned f30;
    longint c;
    for (int i = 0; i < CosEntries; i++) begin
      if (2 * i <= CosEntries) begin
        theta = (PiQ30 * longint'(i)) / CosEntries;
        x2 = (theta * theta) >> 30;
        term = OneQ30;
        c = longint'(OneQ30);
        for (int k = 1; k <= 10; k++) begin
          term = (term * x2) >> 30;
          // series denominator (2k-1)*2k
          case (k)
            1:       term = term >> 1;
            2:       term = term / 64'd12;
            3:       term = term / 64'd30;
            4:       term = term / 64'd56;
            5:       term = term / 64'd90;
            6:       term = term / 64'd132;
            7:       term = term / 64'd182;
            8:       term = term / 64'd240;
            9:       term = term / 64'd306;
            default: term = term / 64'd380;
          endcase
          if (k % 2 == 1) begin
            c = c - longint'(term);
          end else begin
            c = c + longint'(term);
          end
        end
        if (c < 0) c = 0;
        if (c > longint'(OneQ30)) c = longint'(OneQ30);
        f30 = (OneQ30 - longint'(c)) >> 1;
        rom[i] = WeightW'((f30 + 64'd8192) >> 14);
      end else begin
        rom[i] = WeightW'(17'h10000 - rom[CosEntries - i]);
      end
    end
    return rom;
  endfunction

  localparam weight_rom_t WeightRom = build_weight_rom();

  // one restoring remainder step
  function automatic logic [RemW-1:0] wrap_step(logic [RemW-1:0] rem, logic b,
                                                logic [SideW-1:0] side);
    logic [RemW:0] t;
    t = {rem, b};
    if (t >= side) t = t - side;
    return t[RemW-1:0];
  endfunction

  function automatic logic [SideW-1:0] side_of(logic [SideW-1:0] r);
    logic [SideW-1:0] s;
    s = r;
    if (r == '0) s = SideW'(1);
    else if (r > SideW'(LatticeSide)) s = SideW'(LatticeSide);
    return s;
  endfunction

endpackage

>>> rtl/value_noise_octave_sampler_unit.sv
// Top level of the value noise octave sampler: input, address and output stages.
`timescale 1ns / 1ps
// One octave of wrapping, cosine-interpolated value noise in Q16.16. A beat with
// tuser = 0 loads one lattice value at lattice_index; a beat with tuser = 1
// evaluates a field cell and returns one beat with prior_value plus the noise,
// saturated at the positive limit. The pipeline takes one beat every clock while
// the output is not stalled; each result passes the input register, multiply,
// three stages of remainder (one stage per 7 quotient bits), address and lattice
// read, three blend stages and the output register. The lattice store is kept
// in four identical 1024 x 31 RAMs, written together, so all four corners are
// read in the same cycle. A stall at the output holds the whole pipeline; loads
// take effect for every evaluate beat accepted after them. The user must write
// configuration only while the block is idle; the block does not enforce this.
// Lattice slots must be loaded before an evaluate beat reads them.
module value_noise_octave_sampler_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // lattice_index[9:0], lattice_value[40:10],
                                      // column[52:41], row[64:53], prior_value[96:65]
  input  logic         s_axis_tuser,  // operation
  // master side
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // field_value[31:0], saturated[32]
  // configuration
  input  logic                           cfg_we_i,
  input  logic [vnos_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vnos_pkg::CfgDataW-1:0]  cfg_data_i
);
  import vnos_pkg::*;

  // configuration registers
  logic [StepW-1:0]  step_x_q, step_y_q;
  logic [SideW-1:0]  width_q, height_q;
  logic [ShiftW-1:0] shift_x_q, shift_y_q;
  logic [SideW-1:0]  side_x, side_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q  <= StepW'(32'h10000);
      step_y_q  <= StepW'(32'h10000);
      width_q   <= SideW'(1);
      height_q  <= SideW'(1);
      shift_x_q <= '0;
      shift_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STEP_X:  step_x_q  <= cfg_data_i[StepW-1:0];
        CFG_STEP_Y:  step_y_q  <= cfg_data_i[StepW-1:0];
        CFG_WIDTH:   width_q   <= cfg_data_i[SideW-1:0];
        CFG_HEIGHT:  height_q  <= cfg_data_i[SideW-1:0];
        CFG_SHIFT_X: shift_x_q <= cfg_data_i[ShiftW-1:0];
        CFG_SHIFT_Y: shift_y_q <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  assign side_x = side_of(width_q);
  assign side_y = side_of(height_q);

  // global advance: everything moves unless the output beat is stuck
  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 1: input register
  logic                s1_valid_q;
  vnos_op_e            s1_op_q;
  logic [AddrW-1:0]    s1_index_q;
  logic [ValW-1:0]     s1_value_q;
  logic [CoordW-1:0]   s1_col_q, s1_row_q;
  logic signed [FieldW-1:0] s1_prior_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (adv) s1_valid_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q    <= vnos_op_e'(s_axis_tuser);
      s1_index_q <= s_axis_tdata[9:0];
      s1_value_q <= s_axis_tdata[40:10];
      s1_col_q   <= s_axis_tdata[52:41];
      s1_row_q   <= s_axis_tdata[64:53];
      s1_prior_q <= s_axis_tdata[96:65];
    end
  end

  // stage 2: position = coordinate * step, integer part shifted
  logic [PosW-1:0]  px, py;
  logic [WrapW-1:0] ax_d, ay_d;
  logic             s2_valid_q;
  vnos_item_t       s2_item_q;
  logic [WrapW-1:0] s2_ax_q, s2_ay_q;

  assign px   = PosW'(s1_col_q) * PosW'(step_x_q);
  assign py   = PosW'(s1_row_q) * PosW'(step_y_q);
  assign ax_d = WrapW'(px[PosW-1:FracW]) + WrapW'(shift_x_q);
  assign ay_d = WrapW'(py[PosW-1:FracW]) + WrapW'(shift_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (adv) s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_item_q.op    <= s1_op_q;
      s2_item_q.index <= s1_index_q;
      s2_item_q.value <= s1_value_q;
      s2_item_q.fx    <= px[FracW-1:0];
      s2_item_q.fy    <= py[FracW-1:0];
      s2_item_q.prior <= s1_prior_q;
      s2_ax_q         <= ax_d;
      s2_ay_q         <= ay_d;
    end
  end

  // stages 3-5: wrap by the lattice sides
  logic            w_valid;
  vnos_item_t      w_item;
  logic [RemW-1:0] x0, y0;

  vnos_wrap u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (s2_valid_q),
    .item_i   (s2_item_q),
    .ax_i     (s2_ax_q),
    .ay_i     (s2_ay_q),
    .side_x_i (side_x),
    .side_y_i (side_y),
    .valid_o  (w_valid),
    .item_o   (w_item),
    .x0_o     (x0),
    .y0_o     (y0)
  );

  // address stage: neighbors, slot addresses, lattice write for loads
  logic [SideW-1:0]   x0p, y0p;
  logic [RemW-1:0]    x1, y1;
  logic [2*SideW-1:0] row0, row1;
  logic [AddrW-1:0]   a_bl, a_br, a_tl, a_tr;
  logic               lat_we;

  assign x0p  = SideW'(x0) + SideW'(1);
  assign y0p  = SideW'(y0) + SideW'(1);
  assign x1   = (x0p == side_x) ? '0 : x0p[RemW-1:0];
  assign y1   = (y0p == side_y) ? '0 : y0p[RemW-1:0];
  assign row0 = (2*SideW)'(y0) * (2*SideW)'(side_x);
  assign row1 = (2*SideW)'(y1) * (2*SideW)'(side_x);
  assign a_bl = AddrW'(row0 + (2*SideW)'(x0));
  assign a_br = AddrW'(row0 + (2*SideW)'(x1));
  assign a_tl = AddrW'(row1 + (2*SideW)'(x0));
  assign a_tr = AddrW'(row1 + (2*SideW)'(x1));
  assign lat_we = adv && w_valid && (w_item.op == OP_LOAD);

  logic [ValW-1:0]  c_bl, c_br, c_tl, c_tr;
  logic [AddrW-1:0] raddr [4];
  logic [ValW-1:0]  rdata [4];

  assign raddr[0] = a_bl;
  assign raddr[1] = a_br;
  assign raddr[2] = a_tl;
  assign raddr[3] = a_tr;

  for (genvar r = 0; r < 4; r++) begin : g_lat
    vnos_ram #(
      .Width (ValW),
      .Depth (StoreDepth)
    ) u_lat (
      .clk_i   (clk_i),
      .we_i    (lat_we),
      .waddr_i (w_item.index),
      .wdata_i (w_item.value),
      .re_i    (adv),
      .raddr_i (raddr[r]),
      .rdata_o (rdata[r])
    );
  end

  assign c_bl = rdata[0];
  assign c_br = rdata[1];
  assign c_tl = rdata[2];
  assign c_tr = rdata[3];

  // lattice read stage, weights alongside the RAM data
  logic                     s6_valid_q;
  logic [WeightW-1:0]       s6_wx_q, s6_wy_q;
  logic signed [FieldW-1:0] s6_prior_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_valid_q <= 1'b0;
    else if (adv) s6_valid_q <= w_valid && (w_item.op == OP_EVAL);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_wx_q    <= WeightRom[w_item.fx[FracW-1 -: RomIdxW]];
      s6_wy_q    <= WeightRom[w_item.fy[FracW-1 -: RomIdxW]];
      s6_prior_q <= w_item.prior;
    end
  end

  // blend stages
  logic                     b_valid;
  logic [FieldW-1:0]        b_noise;
  logic signed [FieldW-1:0] b_prior;

  vnos_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s6_valid_q),
    .bl_i    (c_bl),
    .br_i    (c_br),
    .tl_i    (c_tl),
    .tr_i    (c_tr),
    .wx_i    (s6_wx_q),
    .wy_i    (s6_wy_q),
    .prior_i (s6_prior_q),
    .valid_o (b_valid),
    .noise_o (b_noise),
    .prior_o (b_prior)
  );

  // output register: add and clip at the positive limit (noise is never negative)
  logic signed [FieldW:0]  sum;
  logic [FieldW-1:0]       field_d, field_q;
  logic                    sat_d, sat_q;
  localparam logic signed [FieldW:0] MaxPos = (FieldW + 1)'(32'h7FFFFFFF);

  assign sum = {b_prior[FieldW-1], b_prior} + $signed({1'b0, b_noise});
  always_comb begin
    sat_d   = (sum > MaxPos);
    field_d = sat_d ? MaxPos[FieldW-1:0] : sum[FieldW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= b_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      field_q <= field_d;
      sat_q   <= sat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, sat_q, field_q};

endmodule

>>> rtl/vnos_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vnos_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/vnos_wrap.sv
// Three-stage pipelined remainder unit: wraps the cell coordinates by the lattice sides.
`timescale 1ns / 1ps
module vnos_wrap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  vnos_pkg::vnos_item_t          item_i,
  input  logic [vnos_pkg::WrapW-1:0]    ax_i,
  input  logic [vnos_pkg::WrapW-1:0]    ay_i,
  input  logic [vnos_pkg::SideW-1:0]    side_x_i,
  input  logic [vnos_pkg::SideW-1:0]    side_y_i,
  output logic                          valid_o,
  output vnos_pkg::vnos_item_t          item_o,
  output logic [vnos_pkg::RemW-1:0]     x0_o,
  output logic [vnos_pkg::RemW-1:0]     y0_o
);
  import vnos_pkg::*;

  localparam int Stages   = 3;
  localparam int PerStage = (WrapW + Stages - 1) / Stages;
  localparam int BitIdxW  = $clog2(WrapW);

  logic [Stages-1:0] valid_q;
  vnos_item_t        item_q [Stages];
  logic [WrapW-1:0]  ax_q   [Stages];
  logic [WrapW-1:0]  ay_q   [Stages];
  logic [RemW-1:0]   rx_q   [Stages];
  logic [RemW-1:0]   ry_q   [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic             src_valid;
    vnos_item_t       src_item;
    logic [WrapW-1:0] src_ax, src_ay;
    logic [RemW-1:0]  src_rx, src_ry;
    logic [RemW-1:0]  rx_d, ry_d;

    if (k == 0) begin : g_first
      assign src_valid = valid_i;
      assign src_item  = item_i;
      assign src_ax    = ax_i;
      assign src_ay    = ay_i;
      assign src_rx    = '0;
      assign src_ry    = '0;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src_item  = item_q[k-1];
      assign src_ax    = ax_q[k-1];
      assign src_ay    = ay_q[k-1];
      assign src_rx    = rx_q[k-1];
      assign src_ry    = ry_q[k-1];
    end

    // PerStage bits of the dividend, MSB first
    always_comb begin
      int p;
      rx_d = src_rx;
      ry_d = src_ry;
      for (int j = 0; j < PerStage; j++) begin
        p = WrapW - 1 - k * PerStage - j;
        if (p >= 0) begin
          rx_d = wrap_step(rx_d, src_ax[p[BitIdxW-1:0]], side_x_i);
          ry_d = wrap_step(ry_d, src_ay[p[BitIdxW-1:0]], side_y_i);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        item_q[k] <= src_item;
        ax_q[k]   <= src_ax;
        ay_q[k]   <= src_ay;
        rx_q[k]   <= rx_d;
        ry_q[k]   <= ry_d;
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign item_o  = item_q[Stages-1];
  assign x0_o    = rx_q[Stages-1];
  assign y0_o    = ry_q[Stages-1];

endmodule

>>> rtl/vnos_blend.sv
// Three-stage cosine blend: x blend of both rows, then y blend.
`timescale 1ns / 1ps
module vnos_blend (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               valid_i,
  input  logic [vnos_pkg::ValW-1:0]          bl_i,
  input  logic [vnos_pkg::ValW-1:0]          br_i,
  input  logic [vnos_pkg::ValW-1:0]          tl_i,
  input  logic [vnos_pkg::ValW-1:0]          tr_i,
  input  logic [vnos_pkg::WeightW-1:0]       wx_i,
  input  logic [vnos_pkg::WeightW-1:0]       wy_i,
  input  logic signed [vnos_pkg::FieldW-1:0] prior_i,
  output logic                               valid_o,
  output logic [vnos_pkg::FieldW-1:0]        noise_o,
  output logic signed [vnos_pkg::FieldW-1:0] prior_o
);
  import vnos_pkg::*;

  localparam int ProdW  = ValW + WeightW;
  localparam int Prod2W = FieldW + WeightW;
  localparam logic [WeightW-1:0] One = WeightW'(1) << FracW;
  localparam logic [Prod2W:0]    Half = (Prod2W + 1)'(1) << (FracW - 1);

  logic [2:0]               valid_q;
  logic [ProdW-1:0]         p_q [4];
  logic [WeightW-1:0]       wy1_q, wy2_q;
  logic signed [FieldW-1:0] prior1_q, prior2_q, prior3_q;
  logic [FieldW-1:0]        lower_q, upper_q;
  logic [Prod2W-1:0]        q0_q, q1_q;
  logic [ProdW:0]           sum_lo, sum_up;
  logic [Prod2W:0]          sum_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  assign sum_lo = (ProdW + 1)'(p_q[0]) + (ProdW + 1)'(p_q[1]) + (ProdW + 1)'(Half);
  assign sum_up = (ProdW + 1)'(p_q[2]) + (ProdW + 1)'(p_q[3]) + (ProdW + 1)'(Half);
  assign sum_n  = (Prod2W + 1)'(q0_q) + (Prod2W + 1)'(q1_q) + Half;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // corner products
      p_q[0]   <= ProdW'(bl_i) * ProdW'(One - wx_i);
      p_q[1]   <= ProdW'(br_i) * ProdW'(wx_i);
      p_q[2]   <= ProdW'(tl_i) * ProdW'(One - wx_i);
      p_q[3]   <= ProdW'(tr_i) * ProdW'(wx_i);
      wy1_q    <= wy_i;
      prior1_q <= prior_i;
      // row sums, rounded
      lower_q  <= FieldW'(sum_lo >> FracW);
      upper_q  <= FieldW'(sum_up >> FracW);
      wy2_q    <= wy1_q;
      prior2_q <= prior1_q;
      // y products
      q0_q     <= Prod2W'(lower_q) * Prod2W'(One - wy2_q);
      q1_q     <= Prod2W'(upper_q) * Prod2W'(wy2_q);
      prior3_q <= prior2_q;
    end
  end

  assign valid_o = valid_q[2];
  assign noise_o = FieldW'(sum_n >> FracW);
  assign prior_o = prior3_q;

endmodule

>>> rtl/vnos_checker.sv
// Port-level checker for the value noise octave sampler, bound to the top level.
`timescale 1ns / 1ps
module vnos_port_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata
);

  // a held result beat keeps its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // clip flag only with the positive limit
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'h7FFFFFFF)
    else $error("saturated flag without limit value");

  // input side is open whenever no result is waiting
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:33] == 7'b0)
    else $error("pad bits set");

endmodule

bind value_noise_octave_sampler_unit vnos_port_checker u_vnos_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
